// ----- rtl/core/mccs_pkg.sv -----
package mccs_pkg;

  // Widest selection the block can hold.
  localparam int MAX_THINGS = 52;

  localparam int POS_W  = 6;
  localparam int CNT_W  = 49;
  localparam int SEL_W  = 52;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;

  localparam logic [1:0] REG_NUMBER = 2'd0;
  localparam logic [1:0] REG_TAKEN  = 2'd1;
  localparam logic [1:0] REG_TOTAL  = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0] number_of_things;
    logic [POS_W-1:0] taken_at_a_time;
    logic [CNT_W-1:0] total_count;
  } cfg_t;

  typedef struct packed {
    logic cap;  // item accepted this cycle
    logic wb;   // commit the step and load the result register
  } cmd_t;

endpackage

// ----- rtl/core/mccs_regs.sv -----
module mccs_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mccs_pkg::ADDR_W-1:0]  paddr,
  input  logic [mccs_pkg::DATA_W-1:0]  pwdata,
  output logic [mccs_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output mccs_pkg::cfg_t               cfg
);

  logic [mccs_pkg::POS_W-1:0] n_r;
  logic [mccs_pkg::POS_W-1:0] n_nxt;
  logic [mccs_pkg::POS_W-1:0] m_r;
  logic [mccs_pkg::POS_W-1:0] m_nxt;
  logic [mccs_pkg::CNT_W-1:0] total_r;
  logic [mccs_pkg::CNT_W-1:0] total_nxt;
  logic                       wr_en;
  logic [1:0]                 reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[4:3];

  always_comb begin
    n_nxt     = n_r;
    m_nxt     = m_r;
    total_nxt = total_r;
    if (wr_en) begin
      case (reg_sel)
        mccs_pkg::REG_NUMBER: n_nxt     = pwdata[mccs_pkg::POS_W-1:0];
        mccs_pkg::REG_TAKEN:  m_nxt     = pwdata[mccs_pkg::POS_W-1:0];
        mccs_pkg::REG_TOTAL:  total_nxt = pwdata[mccs_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r     <= mccs_pkg::POS_W'(6);
      m_r     <= mccs_pkg::POS_W'(4);
      total_r <= mccs_pkg::CNT_W'(15);
    end else begin
      n_r     <= n_nxt;
      m_r     <= m_nxt;
      total_r <= total_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      mccs_pkg::REG_NUMBER: prdata = mccs_pkg::DATA_W'(n_r);
      mccs_pkg::REG_TAKEN:  prdata = mccs_pkg::DATA_W'(m_r);
      mccs_pkg::REG_TOTAL:  prdata = mccs_pkg::DATA_W'(total_r);
      default:              prdata = '0;
    endcase
  end

  assign cfg.number_of_things = n_r;
  assign cfg.taken_at_a_time  = m_r;
  assign cfg.total_count      = total_r;

endmodule

// ----- rtl/core/mccs_ctrl.sv -----
module mccs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output mccs_pkg::cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;
  logic out_valid_r;
  logic out_valid_nxt;

  assign in_stall = (state_r != S_IDLE);
  assign cmd.cap  = (state_r == S_IDLE) && in_valid;
  // The step commits only when the result register is free or draining.
  assign cmd.wb   = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (cmd.cap) state_nxt = S_EXEC;
      S_EXEC:  if (cmd.wb) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.wb) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.cap, cmd.wb}))
    else $error("capture and commit in the same cycle");

  a_wb_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb |=> out_valid_r)
    else $error("committed step did not raise out_valid");

  a_no_double_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap |=> !cmd.cap)
    else $error("second item accepted before the first committed");

  a_wb_after_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wb && $past(rst_n)) |-> ($past(cmd.cap) || $past(state_r == S_EXEC)))
    else $error("commit without an accepted item");

endmodule

// ----- rtl/core/mccs_dp.sv -----
module mccs_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mccs_pkg::cfg_t              cfg,
  input  mccs_pkg::cmd_t              cmd,
  input  logic                        in_restart,
  output logic [mccs_pkg::SEL_W-1:0]  out_selection,
  output logic [mccs_pkg::POS_W-1:0]  out_first_flipped,
  output logic [mccs_pkg::POS_W-1:0]  out_second_flipped,
  output logic [mccs_pkg::CNT_W-1:0]  out_step_index,
  output logic                        out_last_in_cycle,
  output logic                        out_config_error
);

  localparam int MAXT = mccs_pkg::MAX_THINGS;
  localparam int PW   = mccs_pkg::POS_W;
  localparam int CW   = mccs_pkg::CNT_W;
  localparam int SW   = mccs_pkg::SEL_W;

  logic [MAXT-1:0] sel_r;
  logic [MAXT-1:0] sel_nxt;
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   cnt_nxt;

  // Capture stage, loaded at the accept edge.
  logic            restart_r;
  logic [PW-1:0]   p_r;
  logic            cn_r;
  logic            found_r;
  logic [CW-1:0]   inc_r;

  logic [PW-1:0]   n;
  logic [PW-1:0]   m;
  logic            err;

  logic            cn;
  logic [PW-1:0]   p_srch;
  logic            found_srch;

  logic [PW-1:0]   i1;
  logic            sfound;
  logic            sb;
  logic            bit_p;
  logic            bit_pm1;
  logic [PW-1:0]   k1;
  logic [PW-1:0]   k2;
  logic [PW-1:0]   p2;
  logic [PW-1:0]   pmin2;
  logic [PW-1:0]   wrap_k2;
  logic            scan;
  logic            j1_odd;
  logic [MAXT-1:0] flip;
  logic [MAXT-1:0] first_mask;
  logic [PW-1:0]   f1;
  logic [PW-1:0]   f2;
  logic [SW-1:0]   sel_view;

  assign n   = cfg.number_of_things;
  assign m   = cfg.taken_at_a_time;
  assign err = (m == '0) || (m >= n) || (int'(n) > MAXT);

  // Nearest position below n whose bit differs from bit n.
  always_comb begin
    cn         = 1'b0;
    p_srch     = '0;
    found_srch = 1'b0;
    for (int i = 0; i < MAXT; i++) begin
      if (i + 1 == int'(n)) cn = sel_r[i];
    end
    for (int i = 0; i < MAXT; i++) begin
      if ((i + 1 < int'(n)) && (sel_r[i] != cn)) begin
        p_srch     = PW'(i + 1);
        found_srch = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      restart_r <= in_restart;
      p_r       <= p_srch;
      cn_r      <= cn;
      found_r   <= found_srch;
      inc_r     <= cnt_r + CW'(1);
    end
  end

  // Right-to-left scan for the highest set bit at positions 2 up to p.
  always_comb begin
    i1      = '0;
    sfound  = 1'b0;
    sb      = 1'b0;
    bit_p   = 1'b0;
    bit_pm1 = 1'b0;
    for (int i = 0; i < MAXT; i++) begin
      if (i + 1 == int'(p_r)) bit_p = sel_r[i];
      if (i + 2 == int'(p_r)) bit_pm1 = sel_r[i];
    end
    for (int i = 1; i < MAXT; i++) begin
      if ((i + 1 <= int'(p_r)) && sel_r[i]) begin
        i1     = PW'(i + 1);
        sfound = 1'b1;
        sb     = sel_r[i-1];
      end
    end
  end

  always_comb begin
    j1_odd  = n[0] ^ p_r[0];
    p2      = p_r + PW'(2);
    pmin2   = (p2 < n) ? p2 : n;
    wrap_k2 = n + PW'(1) - m;
    k1      = p_r;
    k2      = p_r + PW'(1);
    scan    = 1'b0;
    if (!m[0]) begin
      if (cn_r) begin
        if (!j1_odd) begin
          k2 = pmin2;
        end else begin
          scan = 1'b1;
        end
      end
    end else begin
      if (cn_r) begin
        if (!j1_odd) begin
          scan = 1'b1;
        end else begin
          k2 = pmin2;
        end
      end else if (p_r == PW'(1)) begin
        k1 = PW'(1);
        k2 = wrap_k2;
      end else begin
        k2 = p_r - PW'(1);
        k1 = (bit_p && bit_pm1) ? n : p_r;
      end
    end
    if (scan) begin
      if (sfound) begin
        k1 = i1 - PW'(1);
        k2 = sb ? p_r : p_r + PW'(1);
      end else begin
        k1 = PW'(1);
        k2 = wrap_k2;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAXT; i++) begin
      flip[i]       = (i + 1 == int'(k1)) ^ (i + 1 == int'(k2));
      first_mask[i] = (i < int'(m));
    end
  end

  always_comb begin
    sel_nxt = sel_r;
    cnt_nxt = cnt_r;
    f1      = '0;
    f2      = '0;
    if (!err) begin
      if (restart_r) begin
        sel_nxt = first_mask;
        cnt_nxt = '0;
      end else if (found_r) begin
        sel_nxt = sel_r ^ flip;
        cnt_nxt = inc_r;
        f1      = k1;
        f2      = k2;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SW; i++) begin
      sel_view[i] = (i < MAXT) ? sel_nxt[i % MAXT] : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= '0;
      cnt_r <= '0;
    end else if (cmd.wb) begin
      sel_r <= sel_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      out_selection      <= sel_view;
      out_first_flipped  <= f1;
      out_second_flipped <= f2;
      out_step_index     <= cnt_nxt;
      out_last_in_cycle  <= (cnt_nxt == cfg.total_count);
      out_config_error   <= err;
    end
  end

  a_flip_two: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wb && !err && !restart_r && found_r) |-> ($countones(flip) == 2))
    else $error("step does not complement exactly two positions");

  a_hold_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wb && err) |=> ($stable(sel_r) && $stable(cnt_r)))
    else $error("state changed under a bad configuration");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.wb && $past(rst_n)) |=> ($stable(sel_r) && $stable(cnt_r)))
    else $error("state changed outside a commit");

endmodule

// ----- rtl/core/minimal_change_combination_stepper_unit.sv -----
// Minimal-change stepper over m-of-n selections: each advance item complements
// exactly two positions (the state holds on a bad configuration or when no bit
// below n differs from bit n), a restart item loads positions 1..m and clears
// the step index, and the user must set n, m and the cycle length C(n,m)
// through the register port while the block is idle, which the block does not
// enforce. At the accept edge the search for the position nearest n whose bit
// differs from bit n is registered; in the execute state, once the result
// register is free, the right-to-left scan, the two bit flips and the index
// update are committed into it. in_stall is high in the execute state, also
// while a finished result waits at a stalled output, until the item commits.
module minimal_change_combination_stepper_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mccs_pkg::ADDR_W-1:0] paddr,
  input  logic [mccs_pkg::DATA_W-1:0] pwdata,
  output logic [mccs_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_restart,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mccs_pkg::SEL_W-1:0]  out_selection,
  output logic [mccs_pkg::POS_W-1:0]  out_first_flipped,
  output logic [mccs_pkg::POS_W-1:0]  out_second_flipped,
  output logic [mccs_pkg::CNT_W-1:0]  out_step_index,
  output logic                        out_last_in_cycle,
  output logic                        out_config_error
);

  mccs_pkg::cfg_t cfg;
  mccs_pkg::cmd_t cmd;

  mccs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mccs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  mccs_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .cmd                (cmd),
    .in_restart         (in_restart),
    .out_selection      (out_selection),
    .out_first_flipped  (out_first_flipped),
    .out_second_flipped (out_second_flipped),
    .out_step_index     (out_step_index),
    .out_last_in_cycle  (out_last_in_cycle),
    .out_config_error   (out_config_error)
  );

endmodule
